// ----- hdl/cmseq_pkg.sv -----
// Package for the compressor mode sequencer: payload, state and configuration
// types, relay bit positions, fixed pulse lengths and the mode and command codes.
// No dependencies.
package cmseq_pkg;

  localparam int PRESSURE_BITS = 12;
  localparam int TIMER_BITS    = 17;
  localparam int ELAPSED_BITS  = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 17;

  // fixed times in ms
  localparam logic [TIMER_BITS-1:0] PULSE_MS = 17'd2000;
  localparam logic [TIMER_BITS-1:0] BLEED_MS = 17'd5000;
  localparam logic [TIMER_BITS-1:0] PUMP_MS  = 17'd10000;

  // command codes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // mode codes
  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_STOPPING  = 3'd1;
  localparam logic [2:0] MODE_CHILL_ON  = 3'd2;
  localparam logic [2:0] MODE_CHILL_OFF = 3'd3;
  localparam logic [2:0] MODE_MOTOR_ON  = 3'd4;
  localparam logic [2:0] MODE_FAULT     = 3'd5;
  localparam logic [2:0] MODE_RECHECK   = 3'd6;

  // relay bit positions
  localparam int R_START = 0;
  localparam int R_STOP  = 1;
  localparam int R_BLEED = 2;
  localparam int R_MOTOR = 3;
  localparam int R_PUMP  = 4;
  localparam int R_CHILL = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_TRIGGER     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_TRIGGER    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_CHILLER_OFF = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_MOTOR_READY = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_FAULT      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHILLER_WAIT_MS = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOTOR_CHECK_MS  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHUTDOWN_LIMIT  = 3'd7;

  typedef struct packed {
    logic [1:0]               operation;
    logic [PRESSURE_BITS-1:0] low_side;
    logic [PRESSURE_BITS-1:0] high_side;
    logic [ELAPSED_BITS-1:0]  elapsed_ms;
  } cmseq_in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       start_relay;
    logic       stop_relay;
    logic       bleed_relay;
    logic       motor_relay;
    logic       pump_relay;
    logic       chiller_relay;
    logic       running;
  } cmseq_out_t;

  typedef struct packed {
    logic [PRESSURE_BITS-1:0] low_trigger;
    logic [PRESSURE_BITS-1:0] high_trigger;
    logic [PRESSURE_BITS-1:0] low_chiller_off;
    logic [PRESSURE_BITS-1:0] low_motor_ready;
    logic [PRESSURE_BITS-1:0] high_fault;
    logic [TIMER_BITS-1:0]    chiller_wait_ms;
    logic [TIMER_BITS-1:0]    motor_check_ms;
    logic [1:0]               shutdown_limit;
  } cmseq_cfg_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic                     run_enable;
    logic [5:0]               relays;
    logic [TIMER_BITS-1:0]    chill_wait_left;
    logic [TIMER_BITS-1:0]    pump_delay_left;
    logic [TIMER_BITS-1:0]    motor_check_left;
    logic [TIMER_BITS-1:0]    start_pulse_left;
    logic [TIMER_BITS-1:0]    stop_pulse_left;
    logic [TIMER_BITS-1:0]    recheck_left;
    logic [TIMER_BITS-1:0]    bleed_pulse_left;
    logic [PRESSURE_BITS-1:0] best_high_pressure;
    logic [1:0]               stall_count;
  } cmseq_state_t;

endpackage

// ----- hdl/cmseq_cfg.sv -----
// Configuration register bank of the compressor mode sequencer.
// Depends on cmseq_pkg for the register indexes and the cmseq_cfg_t type.
module cmseq_cfg import cmseq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cmseq_cfg_t               cfg
);

  cmseq_cfg_t cfg_r;

  // register writes, reset to the default thresholds and times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_trigger     <= PRESSURE_BITS'(60);
      cfg_r.high_trigger    <= PRESSURE_BITS'(350);
      cfg_r.low_chiller_off <= PRESSURE_BITS'(97);
      cfg_r.low_motor_ready <= PRESSURE_BITS'(90);
      cfg_r.high_fault      <= PRESSURE_BITS'(400);
      cfg_r.chiller_wait_ms <= TIMER_BITS'(120000);
      cfg_r.motor_check_ms  <= TIMER_BITS'(30000);
      cfg_r.shutdown_limit  <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_TRIGGER:     cfg_r.low_trigger     <= cfg_wdata[PRESSURE_BITS-1:0];
        CFG_HIGH_TRIGGER:    cfg_r.high_trigger    <= cfg_wdata[PRESSURE_BITS-1:0];
        CFG_LOW_CHILLER_OFF: cfg_r.low_chiller_off <= cfg_wdata[PRESSURE_BITS-1:0];
        CFG_LOW_MOTOR_READY: cfg_r.low_motor_ready <= cfg_wdata[PRESSURE_BITS-1:0];
        CFG_HIGH_FAULT:      cfg_r.high_fault      <= cfg_wdata[PRESSURE_BITS-1:0];
        CFG_CHILLER_WAIT_MS: cfg_r.chiller_wait_ms <= cfg_wdata[TIMER_BITS-1:0];
        CFG_MOTOR_CHECK_MS:  cfg_r.motor_check_ms  <= cfg_wdata[TIMER_BITS-1:0];
        CFG_SHUTDOWN_LIMIT:  cfg_r.shutdown_limit  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/cmseq_step.sv -----
// Next-state logic of the compressor mode sequencer: timer countdown, then the
// mode rules in order. Depends on cmseq_pkg for the state, input and config types.
module cmseq_step import cmseq_pkg::*; (
  input  cmseq_state_t cur,
  input  cmseq_in_t    item,
  input  cmseq_cfg_t   cfg,
  output cmseq_state_t nxt
);

  // saturating countdown by the elapsed time
  function automatic logic [TIMER_BITS-1:0] tdec(input logic [TIMER_BITS-1:0] t,
                                                 input logic [TIMER_BITS-1:0] ms);
    tdec = (t > ms) ? (t - ms) : '0;
  endfunction

  function automatic logic tfire(input logic [TIMER_BITS-1:0] t,
                                 input logic [TIMER_BITS-1:0] ms);
    tfire = (t != '0) && (t <= ms);
  endfunction

  always_comb begin
    cmseq_state_t s;
    logic [TIMER_BITS-1:0] ms;
    logic [PRESSURE_BITS-1:0] pl;
    logic [PRESSURE_BITS-1:0] ph;
    logic [1:0] stall_inc;
    logic chill_fire;
    logic start_fire;
    s  = cur;
    ms = TIMER_BITS'(item.elapsed_ms);
    pl = item.low_side;
    ph = item.high_side;

    // command first
    if (item.operation == OP_START) begin
      s.run_enable = 1'b1;
    end else if (item.operation == OP_STOP) begin
      s.run_enable = 1'b0;
      s.mode       = MODE_STOPPING;
    end

    // timers; chiller wait expiry arms the start pulse, which counts the same step
    chill_fire        = tfire(cur.chill_wait_left, ms);
    s.chill_wait_left = tdec(cur.chill_wait_left, ms);
    if (chill_fire) begin
      s.relays[R_START]  = 1'b1;
      s.start_pulse_left = PULSE_MS;
    end
    if (tfire(cur.pump_delay_left, ms)) begin
      s.relays[R_PUMP] = 1'b1;
    end
    s.pump_delay_left  = tdec(cur.pump_delay_left, ms);
    s.motor_check_left = tdec(cur.motor_check_left, ms);
    start_fire         = tfire(s.start_pulse_left, ms);
    s.start_pulse_left = tdec(s.start_pulse_left, ms);
    if (start_fire) begin
      s.relays[R_START] = 1'b0;
    end
    if (tfire(cur.stop_pulse_left, ms)) begin
      s.relays[R_STOP] = 1'b0;
    end
    s.stop_pulse_left = tdec(cur.stop_pulse_left, ms);
    s.recheck_left    = tdec(cur.recheck_left, ms);
    if (tfire(cur.bleed_pulse_left, ms)) begin
      s.relays[R_BLEED] = 1'b0;
    end
    s.bleed_pulse_left = tdec(cur.bleed_pulse_left, ms);

    stall_inc = (s.stall_count == 2'd3) ? s.stall_count : s.stall_count + 2'd1;

    if (s.run_enable) begin
      s.mode = MODE_IDLE;
      // chill start
      if ((pl < cfg.low_trigger || ph < cfg.high_trigger) && !s.relays[R_CHILL]) begin
        s.mode            = MODE_CHILL_ON;
        s.relays[R_CHILL] = 1'b1;
        s.chill_wait_left = cfg.chiller_wait_ms;
      end
      // chill stop
      if (pl > cfg.low_chiller_off && s.relays[R_CHILL]) begin
        s.mode            = MODE_CHILL_OFF;
        s.relays[R_STOP]  = 1'b1;
        s.relays[R_CHILL] = 1'b0;
        s.stop_pulse_left = PULSE_MS;
      end
      // motor start
      if (s.chill_wait_left == '0 && ph < cfg.high_trigger &&
          pl > cfg.low_motor_ready && !s.relays[R_MOTOR]) begin
        s.mode               = MODE_MOTOR_ON;
        s.relays[R_BLEED]    = 1'b1;
        s.relays[R_MOTOR]    = 1'b1;
        s.bleed_pulse_left   = BLEED_MS;
        s.pump_delay_left    = PUMP_MS;
        s.motor_check_left   = cfg.motor_check_ms;
        s.best_high_pressure = ph;
      end
      // overpressure or low suction trip
      if ((ph > cfg.high_fault || pl < cfg.low_trigger) && s.relays[R_MOTOR]) begin
        s.mode             = MODE_FAULT;
        s.relays[R_BLEED]  = 1'b1;
        s.relays[R_MOTOR]  = 1'b0;
        s.relays[R_PUMP]   = 1'b0;
        s.bleed_pulse_left = BLEED_MS;
        s.pump_delay_left  = '0;
      end
      // progress recheck and shutdown
      if (s.motor_check_left == '0 && s.recheck_left == '0 && s.relays[R_MOTOR]) begin
        s.mode = MODE_RECHECK;
        if (ph > s.best_high_pressure) begin
          s.motor_check_left   = cfg.motor_check_ms;
          s.best_high_pressure = ph;
          s.stall_count        = 2'd0;
        end else if (stall_inc >= cfg.shutdown_limit) begin
          s.mode             = MODE_STOPPING;
          s.relays           = 6'b0;
          s.relays[R_STOP]   = 1'b1;
          s.relays[R_BLEED]  = 1'b1;
          s.stall_count      = 2'd0;
          s.chill_wait_left  = '0;
          s.pump_delay_left  = '0;
          s.stop_pulse_left  = PULSE_MS;
          s.bleed_pulse_left = PULSE_MS;
          s.run_enable       = 1'b0;
        end else begin
          s.stall_count  = stall_inc;
          s.recheck_left = cfg.motor_check_ms;
        end
      end
    end else if (s.mode == MODE_STOPPING) begin
      // stop sequence after the latch drops
      s.relays           = 6'b0;
      s.relays[R_STOP]   = 1'b1;
      s.relays[R_BLEED]  = 1'b1;
      s.stall_count      = 2'd0;
      s.chill_wait_left  = '0;
      s.pump_delay_left  = '0;
      s.stop_pulse_left  = PULSE_MS;
      s.bleed_pulse_left = PULSE_MS;
      s.mode             = MODE_IDLE;
    end

    nxt = s;
  end

endmodule

// ----- hdl/compressor_mode_sequencer_unit.sv -----
// Each item passes the input register, then the step logic into the result register.
// Throughput: one item per cycle while out_ready drains the result register; the step
// logic updates the sequencer state in the same cycle it forms the result, so items
// follow back to back.
// Reset (rst_n, synchronous): all timers, relays, mode and latch cleared,
// configuration back to defaults, both stages empty.
module compressor_mode_sequencer_unit import cmseq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cmseq_in_t                in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cmseq_out_t               out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cmseq_cfg_t   cfg;
  cmseq_state_t state_r;
  cmseq_state_t state_nxt;
  cmseq_in_t    item_r;
  logic         item_valid_r;
  cmseq_out_t   out_r;
  logic         out_valid_r;
  logic         advance;

  cmseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cmseq_step u_step (
    .cur  (state_r),
    .item (item_r),
    .cfg  (cfg),
    .nxt  (state_nxt)
  );

  // the held item moves on when the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  // sequencer state commits once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (item_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      out_r.mode          <= state_nxt.mode;
      out_r.start_relay   <= state_nxt.relays[R_START];
      out_r.stop_relay    <= state_nxt.relays[R_STOP];
      out_r.bleed_relay   <= state_nxt.relays[R_BLEED];
      out_r.motor_relay   <= state_nxt.relays[R_MOTOR];
      out_r.pump_relay    <= state_nxt.relays[R_PUMP];
      out_r.chiller_relay <= state_nxt.relays[R_CHILL];
      out_r.running       <= state_nxt.run_enable;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a processed item always lands in the result register
  a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && advance) |=> out_valid_r)
    else $error("processed item did not reach result register");

  // the pump only runs behind a running motor
  a_pump_needs_motor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.relays[R_PUMP] |-> state_r.relays[R_MOTOR])
    else $error("pump relay on without motor relay");

  // while latched on the stopping mode cannot be reported
  a_run_not_stopping: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.running) |-> (out_r.mode != MODE_STOPPING))
    else $error("stopping mode reported while running");

  // mode code stays within the defined set
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode != 3'd7)
    else $error("undefined mode code");

endmodule
